@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define FDL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define FDL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define FDL_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/fdl_pkg.sv @@
// Package with the shared types and constants of the fractional delay line.
`timescale 1ns / 1ps

package fdl_pkg;

    // Ring length in samples; the tap arithmetic relies on a power of two.
    localparam int DEPTH       = 2048;
    localparam int AW          = $clog2(DEPTH);
    localparam int SAMPLE_W    = 16;
    localparam int IN_W        = 32;
    localparam int DELAY_W     = 27;
    localparam int FRAC_W      = 16;
    localparam int OUT_W       = 32;
    localparam int PROD_W      = 2 * (SAMPLE_W + 1);

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_WIDE   = 2'd1,
        MODE_NARROW = 2'd2,
        MODE_DIRECT = 2'd3
    } t_mode;

endpackage

@@ rtl/core/fdl_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module fdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/fractional_delay_line_core.sv @@
// Top level of the fractional delay line: ring memories, tap pipeline and output register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------------
//  in      | to block  | i_in_valid / o_in_stall    | i_mode, i_sample_in, i_delay_fixed
//  out     | from block| o_out_valid / i_out_stall  | o_sample_out
//
// One item per cycle unless stalled; reads pass stage 1, stage 2 and the output register.
// Two copies of the ring memory, written together, supply both taps in the same cycle.
// Entries not yet written read as zero through a fill flag, so reset needs no clearing pass.
// Stalls only back up into the input once all pipeline stages hold read results.
`timescale 1ns / 1ps

module fractional_delay_line_core
    import fdl_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_mode,
    input  logic signed [IN_W-1:0]     i_sample_in,
    input  logic [DELAY_W-1:0]         i_delay_fixed,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [OUT_W-1:0]    o_sample_out
);

    localparam logic [AW-1:0] WP_LAST = AW'(DEPTH - 1);

    // Write side state.
    logic [AW-1:0]              r_wp;
    logic [AW-1:0]              n_wp;
    logic                       r_full;

    // Stage 1: memory read data.
    logic                       r_v1;
    t_mode                      r_mode1;
    logic                       r_ok0;
    logic                       r_ok1;
    logic [FRAC_W-1:0]          r_w1;

    // Stage 2: weighted difference.
    logic                       r_v2;
    t_mode                      r_mode2;
    logic signed [SAMPLE_W-1:0] r_y0_2;
    logic signed [PROD_W-1:0]   r_diffw;

    // Output register.
    logic                       r_out_valid;
    logic signed [OUT_W-1:0]    r_sample_out;
    logic signed [OUT_W-1:0]    n_sample_out;

    logic                       en_out;
    logic                       en2;
    logic                       en1;
    logic                       acc;
    logic                       acc_push;
    logic                       acc_read;
    t_mode                      in_mode;
    logic [FRAC_W-1:0]          frac;
    logic [AW-1:0]              idx0;
    logic [AW-1:0]              idx1;
    logic [SAMPLE_W-1:0]        q0;
    logic [SAMPLE_W-1:0]        q1;
    logic signed [SAMPLE_W-1:0] y0;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0]        sum16;

    // Each stage moves on when the one after it is empty or moving.
    assign en_out     = !r_out_valid || !i_out_stall;
    assign en2        = !r_v2 || en_out;
    assign en1        = !r_v1 || en2;
    assign o_in_stall = !en1;

    assign in_mode  = t_mode'(i_mode);
    assign acc      = i_in_valid && en1;
    assign acc_push = acc && (in_mode == MODE_PUSH);
    assign acc_read = acc && (in_mode != MODE_PUSH);

    // Tap index: whole samples back from the pointer, one more when a fraction remains.
    assign frac = i_delay_fixed[FRAC_W-1:0];
    assign idx0 = r_wp - i_delay_fixed[FRAC_W +: AW] - AW'(|frac);
    assign idx1 = idx0 + AW'(1);

    assign n_wp = (r_wp == WP_LAST) ? '0 : r_wp + AW'(1);

    fdl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram_tap0 (
        .i_clk   (i_clk),
        .i_we    (acc_push),
        .i_waddr (r_wp),
        .i_wdata (i_sample_in[IN_W-1 -: SAMPLE_W]),
        .i_re    (acc_read),
        .i_raddr (idx0),
        .o_rdata (q0)
    );

    fdl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram_tap1 (
        .i_clk   (i_clk),
        .i_we    (acc_push),
        .i_waddr (r_wp),
        .i_wdata (i_sample_in[IN_W-1 -: SAMPLE_W]),
        .i_re    (acc_read),
        .i_raddr (idx1),
        .o_rdata (q1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_full      <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc_push) begin
                r_wp <= n_wp;
                if (r_wp == WP_LAST) begin
                    r_full <= 1'b1;
                end
            end
            if (en1) begin
                r_v1 <= acc_read;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en_out) begin
                r_out_valid <= r_v2;
            end
        end
    end

    // Until the ring has wrapped once, only entries below the pointer hold samples.
    always_ff @(posedge i_clk) begin
        if (acc_read) begin
            r_mode1 <= in_mode;
            r_ok0   <= r_full || (idx0 < r_wp);
            r_ok1   <= r_full || (idx1 < r_wp);
            r_w1    <= ~frac;
        end
        if (en2 && r_v1) begin
            r_mode2 <= r_mode1;
            r_y0_2  <= y0;
            r_diffw <= prod;
        end
        if (en_out && r_v2) begin
            r_sample_out <= n_sample_out;
        end
    end

    assign y0   = r_ok0 ? $signed(q0) : '0;
    assign y1   = r_ok1 ? $signed(q1) : '0;
    assign diff = (SAMPLE_W + 1)'(y1) - (SAMPLE_W + 1)'(y0);
    assign prod = PROD_W'(diff * $signed({1'b0, r_w1}));

    // Bits above 15 of the weighted difference are its floor after a shift by 16.
    assign sum16 = r_y0_2 + r_diffw[2*FRAC_W-1:FRAC_W];

    always_comb begin
        case (r_mode2)
            MODE_WIDE: begin
                n_sample_out = {r_y0_2, {FRAC_W{1'b0}}} + r_diffw[OUT_W-1:0];
            end
            MODE_NARROW: begin
                n_sample_out = {{(OUT_W - SAMPLE_W){sum16[SAMPLE_W-1]}}, sum16};
            end
            default: begin
                n_sample_out = {r_y0_2, {FRAC_W{1'b0}}};
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

endmodule

@@ rtl/core/fdl_checker.sv @@
// Port-level checker for the fractional delay line and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fdl_checker
    import fdl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    o_in_stall,
    input  logic                    o_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [OUT_W-1:0] o_sample_out
);

    `FDL_ASSERT_RST(a_reset_clears, !i_rst_n, !o_out_valid && !o_in_stall, "reset left a beat")
    `FDL_ASSERT_IMP(a_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled freely")
    `FDL_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "output beat dropped")
    `FDL_ASSERT_NXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_sample_out), "stalled output changed")

endmodule

bind fractional_delay_line_core fdl_checker u_fdl_checker (.*);

@@ dv/tb_fractional_delay_line_core.sv @@
// Self-checking testbench of the fractional delay line core with its own tap predictor.
`timescale 1ns / 1ps

module tb_fractional_delay_line_core;
    import fdl_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SHOWN_ERRORS = 10;
    localparam int SETTLE       = 8;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_in_valid    = 1'b0;
    logic                    o_in_stall;
    logic [1:0]              i_mode        = MODE_PUSH;
    logic signed [IN_W-1:0]  i_sample_in   = '0;
    logic [DELAY_W-1:0]      i_delay_fixed = '0;
    logic                    o_out_valid;
    logic                    i_out_stall   = 1'b0;
    logic signed [OUT_W-1:0] o_sample_out;

    // Shadow of the ring and its write pointer, updated at each accepted push beat.
    logic [SAMPLE_W-1:0] ring_img [DEPTH];
    logic [AW-1:0]       wr_ptr;
    logic [OUT_W-1:0]    pending_taps [$];

    int   errors         = 0;
    int   cycles         = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_off       = 1'b0;

    fractional_delay_line_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_sample_in   (i_sample_in),
        .i_delay_fixed (i_delay_fixed),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sample_out  (o_sample_out)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Tap value for a read at the current pointer: linear weighting of two neighbors.
    function automatic logic [OUT_W-1:0] tap_value(input t_mode m,
                                                   input logic [DELAY_W-1:0] d);
        logic [DELAY_W-1:0]  pos;
        logic [AW-1:0]       i0;
        logic [AW-1:0]       i1;
        longint              y0;
        longint              y1;
        longint              w;
        longint              wdiff;
        longint              acc;
        logic [SAMPLE_W-1:0] n16;
        pos   = {wr_ptr, {FRAC_W{1'b0}}} - d;
        i0    = pos[DELAY_W-1:FRAC_W];
        i1    = i0 + 1'b1;
        y0    = $signed(ring_img[i0]);
        y1    = $signed(ring_img[i1]);
        w     = {48'd0, ~d[FRAC_W-1:0]};
        wdiff = (y1 - y0) * w;
        case (m)
            MODE_WIDE: begin
                acc = y0 * 65536 + wdiff;
                return acc[OUT_W-1:0];
            end
            MODE_NARROW: begin
                acc = y0 + (wdiff >>> 16);
                n16 = acc[SAMPLE_W-1:0];
                return {{(OUT_W-SAMPLE_W){n16[SAMPLE_W-1]}}, n16};
            end
            default: begin
                acc = y0 * 65536;
                return acc[OUT_W-1:0];
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : result_monitor
        logic [OUT_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_taps.size() == 0) begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("unexpected result beat: sample_out %h", o_sample_out);
            end else begin
                want = pending_taps.pop_front();
                if (o_sample_out !== want) begin
                    errors++;
                    if (errors <= SHOWN_ERRORS)
                        $display("sample_out mismatch: expected %h, got %h", want,
                                 o_sample_out);
                end
            end
        end
        i_out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic send_beat(input t_mode m, input logic [IN_W-1:0] s,
                             input logic [DELAY_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= m;
        i_sample_in   <= s;
        i_delay_fixed <= d;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (m == MODE_PUSH) begin
            ring_img[wr_ptr] = s[IN_W-1:IN_W-SAMPLE_W];
            wr_ptr = wr_ptr + 1'b1;
        end else begin
            pending_taps.push_back(tap_value(m, d));
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_taps.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic test_directed();
        // Reads of the cleared ring in every mode, one of them at the longest delay.
        send_beat(MODE_WIDE, '0, '0);
        send_beat(MODE_NARROW, '0, 27'h0018000);
        send_beat(MODE_DIRECT, '0, 27'h7ffffff);
        // Sample extremes; only the upper half of each word is kept.
        send_beat(MODE_PUSH, 32'h7fffffff, '0);
        send_beat(MODE_PUSH, 32'h80000000, '0);
        send_beat(MODE_PUSH, 32'hffffffff, '0);
        send_beat(MODE_PUSH, 32'h0000ffff, '0);
        send_beat(MODE_PUSH, 32'h12345678, '0);
        // Tap on the largest positive sample next to the most negative one, full weight.
        send_beat(MODE_WIDE, '0, 27'h0050000);
        send_beat(MODE_NARROW, '0, 27'h0050000);
        send_beat(MODE_DIRECT, '0, 27'h0050000);
        // Fraction of all ones gives zero weight, then two taps with a fraction of one half.
        send_beat(MODE_WIDE, '0, 27'h004ffff);
        send_beat(MODE_NARROW, '0, 27'h004ffff);
        send_beat(MODE_WIDE, '0, 27'h0048000);
        send_beat(MODE_NARROW, '0, 27'h0038000);
        // Tap on the last entry, whose neighbor is entry zero.
        send_beat(MODE_WIDE, '0, 27'h0060000);
        send_beat(MODE_NARROW, '0, 27'h005c000);
        // Delays that wrap the tap round the ring, then the shortest nonzero delay.
        send_beat(MODE_WIDE, '0, 27'h7ffffff);
        send_beat(MODE_NARROW, '0, 27'h4050000);
        send_beat(MODE_DIRECT, '0, 27'h0000001);
        drain();
    endtask

    task automatic random_beat();
        t_mode              m;
        logic [IN_W-1:0]    s;
        logic [DELAY_W-1:0] d;
        int                 pick;
        s    = $urandom;
        pick = $urandom_range(99);
        if (pick < 10)
            s[IN_W-1:IN_W-SAMPLE_W] = pick[0] ? 16'h7fff : 16'h8000;
        m = ($urandom_range(99) < 45) ? MODE_PUSH : t_mode'($urandom_range(3, 1));
        // Mostly short delays, so that the tap falls on recently pushed samples.
        d    = DELAY_W'($urandom);
        pick = $urandom_range(9);
        if (pick >= 2)
            d[DELAY_W-1:FRAC_W] = AW'($urandom_range(40));
        if (pick == 2)
            d[FRAC_W-1:0] = '0;
        else if (pick == 3)
            d[FRAC_W-1:0] = '1;
        send_beat(m, s, d);
    endtask

    task automatic test_random(input int count);
        repeat (count) random_beat();
        drain();
    endtask

    // The receiver holds off long enough for the pipeline to fill and stall the input.
    task automatic test_backpressure();
        set_idling(0, 0);
        fork
            begin
                hold_off <= 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            repeat (60) begin
                send_beat(t_mode'($urandom_range(3, 1)), $urandom,
                          {AW'($urandom_range(20)), FRAC_W'($urandom)});
            end
        join
        drain();
    endtask

    initial begin
        for (int k = 0; k < DEPTH; k++)
            ring_img[k] = '0;
        wr_ptr = '0;
        set_idling(0, 0);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        set_idling(0, 0);
        test_random(300);
        set_idling(77, 0);
        test_random(300);
        set_idling(0, 77);
        test_random(300);
        set_idling(37, 37);
        test_random(300);
        test_backpressure();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
